// ===== hw/rtl/swl_pkg.sv =====
// shared codes and placement table for the strategy work list
// no dependencies
`timescale 1ns / 1ps

package swl_pkg;

  localparam int ActionWidth   = 3;
  localparam int StrategyWidth = 3;
  localparam int StatusWidth   = 2;

  localparam logic [ActionWidth-1:0] ACT_PUSH     = 3'd0;
  localparam logic [ActionWidth-1:0] ACT_PUSH_DEP = 3'd1;
  localparam logic [ActionWidth-1:0] ACT_POP      = 3'd2;
  localparam logic [ActionWidth-1:0] ACT_REMOVE   = 3'd3;
  localparam logic [ActionWidth-1:0] ACT_FIND     = 3'd4;

  localparam logic [StrategyWidth-1:0] STRAT_DFS      = 3'd0;
  localparam logic [StrategyWidth-1:0] STRAT_BACK_DFS = 3'd1;
  localparam logic [StrategyWidth-1:0] STRAT_CYC_DFS  = 3'd2;
  localparam logic [StrategyWidth-1:0] STRAT_BFS      = 3'd3;
  localparam logic [StrategyWidth-1:0] STRAT_BWD_BFS  = 3'd4;
  localparam logic [StrategyWidth-1:0] STRAT_FWD_BFS  = 3'd5;
  localparam logic [StrategyWidth-1:0] STRAT_BEST     = 3'd6;

  localparam logic [StatusWidth-1:0] STATUS_OK    = 2'd0;
  localparam logic [StatusWidth-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [StatusWidth-1:0] STATUS_FULL  = 2'd2;

  typedef enum logic [1:0] {
    PLACE_FRONT,
    PLACE_BACK,
    PLACE_SORTED
  } place_e;

  function automatic place_e place_for(input logic [StrategyWidth-1:0] strat,
                                       input logic dep);
    place_e p;
    unique case (strat)
      STRAT_BACK_DFS: p = dep ? PLACE_BACK : PLACE_FRONT;
      STRAT_BFS:      p = PLACE_BACK;
      STRAT_BWD_BFS:  p = dep ? PLACE_FRONT : PLACE_BACK;
      STRAT_FWD_BFS:  p = dep ? PLACE_FRONT : PLACE_BACK;
      STRAT_BEST:     p = PLACE_SORTED;
      default:        p = PLACE_FRONT;
    endcase
    return p;
  endfunction

endpackage

// ===== hw/rtl/swl_ram.sv =====
// generic single write port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module swl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== hw/rtl/strategy_work_list.sv =====
// strategy work list: bounded double ended queue with sorted insert
// depends on swl_pkg and swl_ram
`timescale 1ns / 1ps

// usage
//   cfg_valid_i/cfg_ready_o/cfg_strategy_i write the strategy register; ready is
//   always high, writes are meant for idle periods only.
//   an item (action, edge id, rating) is taken when start is high and busy is low.
//   each item yields one result on the output ports, marked by done_o for one cycle.
//   entries live in one ram used as a ring: front and back pushes write one entry
//   and report in the cycle after acceptance without raising busy; pop reads the front
//   entry, stays busy in the pop state and reports as it returns to idle.
//   sorted push, remove and find walk the list through the single ram read port,
//   one entry per cycle: busy for the whole walk, the result showing as busy falls.
//   pushes into a full list and pops from an empty list report at once.
//   reset empties the list and sets the strategy to depth first.
//   the receiver cannot stall: a result is shown for exactly one cycle.
module strategy_work_list
  import swl_pkg::*;
#(
  parameter int DEPTH        = 64,
  parameter int ID_WIDTH     = 16,
  parameter int RATING_WIDTH = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [StrategyWidth-1:0]   cfg_strategy_i,
  input  logic                       start,
  output logic                       busy,
  input  logic [ActionWidth-1:0]     action_i,
  input  logic [ID_WIDTH-1:0]        edge_id_i,
  input  logic [RATING_WIDTH-1:0]    rating_i,
  output logic                       done_o,
  output logic [ID_WIDTH-1:0]        popped_id_o,
  output logic                       popped_valid_o,
  output logic                       found_o,
  output logic [StatusWidth-1:0]     status_o,
  output logic [$clog2(DEPTH+1)-1:0] occupancy_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = ID_WIDTH + RATING_WIDTH;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_POP  = 2'd2;

  localparam logic [1:0] OP_SORT   = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_FIND   = 2'd2;

  function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [CW-1:0] l);
    logic [CW:0] s;
    s = (CW+1)'(h) + (CW+1)'(l);
    if (s >= (CW+1)'(DEPTH)) begin
      s = s - (CW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  logic [1:0]              state_q, state_d;
  logic [1:0]              op_q, op_d;
  logic [StrategyWidth-1:0] strat_q;
  logic [CW-1:0]           cnt_q, cnt_d;
  logic [AW-1:0]           head_q, head_d;
  logic [CW-1:0]           rd_i_q, rd_i_d;
  logic [CW-1:0]           di_q, di_d;
  logic [CW-1:0]           wi_q, wi_d;
  logic                    dv_q, dv_d;
  logic                    placed_q, placed_d;
  logic                    hit_q, hit_d;
  logic [ID_WIDTH-1:0]     key_id_q, key_id_d;
  logic [RATING_WIDTH-1:0] key_rt_q, key_rt_d;
  logic [EW-1:0]           carry_q, carry_d;

  logic                    done_q, done_d;
  logic [ID_WIDTH-1:0]     pid_q, pid_d;
  logic                    pval_q, pval_d;
  logic                    fnd_q, fnd_d;
  logic [StatusWidth-1:0]  stat_q, stat_d;

  logic                    we;
  logic [AW-1:0]           waddr, raddr;
  logic [EW-1:0]           wdata, rdata;
  logic [ID_WIDTH-1:0]     rd_id;
  logic [RATING_WIDTH-1:0] rd_rt;
  logic                    rd_en;
  place_e                  place;
  logic [AW-1:0]           head_dec, head_inc;

  swl_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign rd_id    = rdata[EW-1:RATING_WIDTH];
  assign rd_rt    = rdata[RATING_WIDTH-1:0];
  assign rd_en    = (rd_i_q < cnt_q);
  assign place    = place_for(strat_q, action_i == ACT_PUSH_DEP);
  assign head_dec = (head_q == '0) ? AW'(DEPTH - 1) : head_q - AW'(1);
  assign head_inc = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);

  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    cnt_d    = cnt_q;
    head_d   = head_q;
    rd_i_d   = rd_i_q;
    di_d     = di_q;
    wi_d     = wi_q;
    dv_d     = 1'b0;
    placed_d = placed_q;
    hit_d    = hit_q;
    key_id_d = key_id_q;
    key_rt_d = key_rt_q;
    carry_d  = carry_q;
    done_d   = 1'b0;
    pid_d    = '0;
    pval_d   = 1'b0;
    fnd_d    = 1'b0;
    stat_d   = STATUS_OK;
    we       = 1'b0;
    waddr    = '0;
    wdata    = '0;
    raddr    = phys(head_q, rd_i_q);

    unique case (state_q)
      ST_IDLE: begin
        raddr = head_q;
        if (start) begin
          key_id_d = edge_id_i;
          key_rt_d = rating_i;
          carry_d  = {edge_id_i, rating_i};
          rd_i_d   = '0;
          wi_d     = '0;
          placed_d = 1'b0;
          hit_d    = 1'b0;
          unique case (action_i)
            ACT_PUSH, ACT_PUSH_DEP: begin
              if (cnt_q == CW'(DEPTH)) begin
                done_d = 1'b1;
                stat_d = STATUS_FULL;
              end else begin
                unique case (place)
                  PLACE_FRONT: begin
                    we     = 1'b1;
                    waddr  = head_dec;
                    wdata  = {edge_id_i, rating_i};
                    head_d = head_dec;
                    cnt_d  = cnt_q + CW'(1);
                    done_d = 1'b1;
                  end
                  PLACE_BACK: begin
                    we     = 1'b1;
                    waddr  = phys(head_q, cnt_q);
                    wdata  = {edge_id_i, rating_i};
                    cnt_d  = cnt_q + CW'(1);
                    done_d = 1'b1;
                  end
                  default: begin
                    op_d    = OP_SORT;
                    state_d = ST_SCAN;
                  end
                endcase
              end
            end
            ACT_POP: begin
              if (cnt_q == '0) begin
                done_d = 1'b1;
                stat_d = STATUS_EMPTY;
              end else begin
                state_d = ST_POP;
              end
            end
            ACT_REMOVE: begin
              op_d    = OP_REMOVE;
              state_d = ST_SCAN;
            end
            ACT_FIND: begin
              op_d    = OP_FIND;
              state_d = ST_SCAN;
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      ST_POP: begin
        pid_d   = rd_id;
        pval_d  = 1'b1;
        done_d  = 1'b1;
        head_d  = head_inc;
        cnt_d   = cnt_q - CW'(1);
        state_d = ST_IDLE;
      end
      ST_SCAN: begin
        if (rd_en) begin
          rd_i_d = rd_i_q + CW'(1);
          dv_d   = 1'b1;
          di_d   = rd_i_q;
        end
        if (dv_q) begin
          unique case (op_q)
            OP_SORT: begin
              if (placed_q || (key_rt_q < rd_rt)) begin
                we       = 1'b1;
                waddr    = phys(head_q, di_q);
                wdata    = carry_q;
                carry_d  = rdata;
                placed_d = 1'b1;
              end
            end
            OP_REMOVE: begin
              if (rd_id != key_id_q) begin
                we    = 1'b1;
                waddr = phys(head_q, wi_q);
                wdata = rdata;
                wi_d  = wi_q + CW'(1);
              end
            end
            default: begin
              if (rd_id == key_id_q) begin
                hit_d = 1'b1;
              end
            end
          endcase
        end else if (!rd_en) begin
          done_d  = 1'b1;
          state_d = ST_IDLE;
          unique case (op_q)
            OP_SORT: begin
              we    = 1'b1;
              waddr = phys(head_q, cnt_q);
              wdata = carry_q;
              cnt_d = cnt_q + CW'(1);
            end
            OP_REMOVE: begin
              cnt_d = wi_q;
            end
            default: begin
              fnd_d = hit_q;
            end
          endcase
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      strat_q <= STRAT_DFS;
      cnt_q   <= '0;
      head_q  <= '0;
      dv_q    <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      head_q  <= head_d;
      dv_q    <= dv_d;
      done_q  <= done_d;
      if (cfg_valid_i && cfg_ready_o) begin
        strat_q <= cfg_strategy_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    rd_i_q   <= rd_i_d;
    di_q     <= di_d;
    wi_q     <= wi_d;
    placed_q <= placed_d;
    hit_q    <= hit_d;
    key_id_q <= key_id_d;
    key_rt_q <= key_rt_d;
    carry_q  <= carry_d;
    pid_q    <= pid_d;
    pval_q   <= pval_d;
    fnd_q    <= fnd_d;
    stat_q   <= stat_d;
  end

  assign cfg_ready_o    = 1'b1;
  assign busy           = (state_q != ST_IDLE);
  assign done_o         = done_q;
  assign popped_id_o    = pid_q;
  assign popped_valid_o = pval_q;
  assign found_o        = fnd_q;
  assign status_o       = stat_q;
  assign occupancy_o    = cnt_q;

endmodule

// ===== hw/rtl/swl_checker.sv =====
// port level checks for the strategy work list, bound to the top level
// depends on swl_pkg and strategy_work_list
`timescale 1ns / 1ps

module swl_checker
  import swl_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       start,
  input logic                       busy,
  input logic                       done_o,
  input logic                       popped_valid_o,
  input logic                       found_o,
  input logic [StatusWidth-1:0]     status_o,
  input logic [$clog2(DEPTH+1)-1:0] occupancy_o
);

  // an accepted item either reports next cycle or keeps the block busy
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (done_o || busy))
    else $error("accepted item neither reported nor busy");

  // leaving busy always comes with a result
  a_busy_end_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("busy dropped without a result");

  a_pop_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && popped_valid_o) |-> (status_o == STATUS_OK && !found_o))
    else $error("pop result with bad status or find flag");

  a_empty_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == STATUS_EMPTY) |-> (!popped_valid_o && occupancy_o == '0))
    else $error("empty pop reported with entries or data");

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (occupancy_o <= ($clog2(DEPTH+1))'(DEPTH)))
    else $error("occupancy beyond depth");

endmodule

bind strategy_work_list swl_checker #(
  .DEPTH (DEPTH)
) u_swl_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .done_o         (done_o),
  .popped_valid_o (popped_valid_o),
  .found_o        (found_o),
  .status_o       (status_o),
  .occupancy_o    (occupancy_o)
);

// ===== tb/tb_top.sv =====
// self-checking testbench for strategy_work_list: directed and random items
// are checked against a behavioural copy of the work list held here
// depends on swl_pkg and strategy_work_list
`timescale 1ns / 1ps

module tb_top
  import swl_pkg::*;
();

  localparam int DEPTH  = 64;
  localparam int ID_W   = 16;
  localparam int RATE_W = 16;
  localparam int OCC_W  = $clog2(DEPTH + 1);

  localparam logic [ActionWidth-1:0]   ACT_UNUSED_LO = 3'd5;
  localparam logic [ActionWidth-1:0]   ACT_UNUSED_HI = 3'd7;
  localparam logic [StrategyWidth-1:0] STRAT_UNUSED  = 3'd7;

  localparam int          ChunkLen   = 50;
  localparam int unsigned CycleLimit = 1000000;
  localparam int          DueDepth   = 16;

  typedef struct packed {
    logic [ID_W-1:0]        popped_id;
    logic                   popped_valid;
    logic                   found;
    logic [StatusWidth-1:0] status;
    logic [OCC_W-1:0]       occupancy;
  } outcome_t;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     cfg_valid_i;
  logic                     cfg_ready_o;
  logic [StrategyWidth-1:0] cfg_strategy_i;
  logic                     start;
  logic                     busy;
  logic [ActionWidth-1:0]   action_i;
  logic [ID_W-1:0]          edge_id_i;
  logic [RATE_W-1:0]        rating_i;
  logic                     done_o;
  logic [ID_W-1:0]          popped_id_o;
  logic                     popped_valid_o;
  logic                     found_o;
  logic [StatusWidth-1:0]   status_o;
  logic [OCC_W-1:0]         occupancy_o;

  // behavioural copy of the list
  logic [ID_W-1:0]          list_ids [DEPTH];
  logic [RATE_W-1:0]        list_ratings [DEPTH];
  int                       list_len = 0;
  logic [StrategyWidth-1:0] cur_strategy = STRAT_DFS;

  // results still owed by the block, oldest at due_rd
  outcome_t    due_ring [DueDepth];
  logic [3:0]  due_wr = '0;
  logic [3:0]  due_rd = '0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned sender_idle_pct;

  strategy_work_list #(
    .DEPTH        (DEPTH),
    .ID_WIDTH     (ID_W),
    .RATING_WIDTH (RATE_W)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_strategy_i (cfg_strategy_i),
    .start          (start),
    .busy           (busy),
    .action_i       (action_i),
    .edge_id_i      (edge_id_i),
    .rating_i       (rating_i),
    .done_o         (done_o),
    .popped_id_o    (popped_id_o),
    .popped_valid_o (popped_valid_o),
    .found_o        (found_o),
    .status_o       (status_o),
    .occupancy_o    (occupancy_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("%0t: timeout with %0d results outstanding", $time, 4'(due_wr - due_rd));
      $display("Some tests failed");
      $finish;
    end
  end

  // applies one item to the list copy and returns the result it should give
  function automatic outcome_t list_outcome(input logic [ActionWidth-1:0] act,
                                            input logic [ID_W-1:0] id,
                                            input logic [RATE_W-1:0] rate);
    outcome_t res;
    place_e   where;
    logic     dep;
    int       pos;
    int       idx;
    int       kept;
    res = '0;
    dep = (act == ACT_PUSH_DEP);
    case (act)
      ACT_PUSH, ACT_PUSH_DEP: begin
        if (list_len >= DEPTH) begin
          res.status = STATUS_FULL;
        end else begin
          case (cur_strategy)
            STRAT_BACK_DFS:               where = dep ? PLACE_BACK : PLACE_FRONT;
            STRAT_BFS:                    where = PLACE_BACK;
            STRAT_BWD_BFS, STRAT_FWD_BFS: where = dep ? PLACE_FRONT : PLACE_BACK;
            STRAT_BEST:                   where = PLACE_SORTED;
            default:                      where = PLACE_FRONT;
          endcase
          case (where)
            PLACE_FRONT: pos = 0;
            PLACE_BACK:  pos = list_len;
            default: begin
              // ahead of the first strictly greater rating
              pos = 0;
              while (pos < list_len && !(rate < list_ratings[pos])) pos++;
            end
          endcase
          for (idx = list_len; idx > pos; idx--) begin
            list_ids[idx]     = list_ids[idx-1];
            list_ratings[idx] = list_ratings[idx-1];
          end
          list_ids[pos]     = id;
          list_ratings[pos] = rate;
          list_len++;
        end
      end
      ACT_POP: begin
        if (list_len == 0) begin
          res.status = STATUS_EMPTY;
        end else begin
          res.popped_id    = list_ids[0];
          res.popped_valid = 1'b1;
          for (idx = 1; idx < list_len; idx++) begin
            list_ids[idx-1]     = list_ids[idx];
            list_ratings[idx-1] = list_ratings[idx];
          end
          list_len--;
        end
      end
      ACT_REMOVE: begin
        kept = 0;
        for (idx = 0; idx < list_len; idx++) begin
          if (list_ids[idx] != id) begin
            list_ids[kept]     = list_ids[idx];
            list_ratings[kept] = list_ratings[idx];
            kept++;
          end
        end
        list_len = kept;
      end
      ACT_FIND: begin
        for (idx = 0; idx < list_len; idx++) begin
          if (list_ids[idx] == id) res.found = 1'b1;
        end
      end
      default: ;
    endcase
    res.occupancy = OCC_W'(list_len);
    return res;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // acceptance is handled before the result check so a same-cycle result is safe
  always @(posedge clk_i) begin : result_monitor
    outcome_t got;
    outcome_t want;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) cur_strategy = cfg_strategy_i;
      if (start && !busy) begin
        due_ring[due_wr] = list_outcome(action_i, edge_id_i, rating_i);
        due_wr++;
      end
      if (done_o) begin
        got = {popped_id_o, popped_valid_o, found_o, status_o, occupancy_o};
        if (due_wr == due_rd) begin
          $display("%0t: unexpected result, expected none, got 0x%0h", $time, got);
          mismatches++;
        end else begin
          want = due_ring[due_rd];
          due_rd++;
          check_field("popped_id", 32'(want.popped_id), 32'(got.popped_id));
          check_field("popped_valid", 32'(want.popped_valid), 32'(got.popped_valid));
          check_field("found", 32'(want.found), 32'(got.found));
          check_field("status", 32'(want.status), 32'(got.status));
          check_field("occupancy", 32'(want.occupancy), 32'(got.occupancy));
        end
      end
    end
  end

  // entered and left at a falling edge; start stays high between items unless an idle gap is drawn
  task automatic send_item(input logic [ActionWidth-1:0] act, input logic [ID_W-1:0] id,
                           input logic [RATE_W-1:0] rate);
    int unsigned gap;
    if ($urandom_range(0, 99) < sender_idle_pct) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 80) : $urandom_range(1, 3);
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start     <= 1'b1;
    action_i  <= act;
    edge_id_i <= id;
    rating_i  <= rate;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    do @(negedge clk_i); while (due_wr != due_rd || busy);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic set_strategy(input logic [StrategyWidth-1:0] strat);
    wait_idle();
    cfg_valid_i    <= 1'b1;
    cfg_strategy_i <= strat;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // depth first after reset: empty pop, field extremes, find, remove, unused codes
  task automatic test_basic();
    send_item(ACT_POP, '0, '0);
    send_item(ACT_PUSH, '0, '0);
    send_item(ACT_PUSH_DEP, 16'hffff, 16'hffff);
    send_item(ACT_FIND, 16'hffff, '0);
    send_item(ACT_FIND, 16'h1234, 16'hffff);
    send_item(ACT_POP, '0, '0);
    send_item(ACT_REMOVE, 16'h5555, '0);
    send_item(ACT_UNUSED_LO, 16'haaaa, 16'h5555);
    send_item(ACT_UNUSED_HI, 16'h5555, 16'haaaa);
    send_item(ACT_REMOVE, '0, '0);
    send_item(ACT_POP, '0, '0);
  endtask

  // equal ratings keep arrival order, extremes go to the ends
  task automatic test_best_first();
    set_strategy(STRAT_BEST);
    send_item(ACT_PUSH, 16'd1, 16'd5);
    send_item(ACT_PUSH_DEP, 16'd2, 16'd5);
    send_item(ACT_PUSH, 16'd3, 16'hffff);
    send_item(ACT_PUSH_DEP, 16'd4, '0);
    repeat (4) send_item(ACT_POP, '0, '0);
  endtask

  // the spare strategy code behaves as depth first
  task automatic test_unused_strategy();
    set_strategy(STRAT_UNUSED);
    send_item(ACT_PUSH, 16'h00a0, 16'h0010);
    send_item(ACT_PUSH_DEP, 16'h00b0, 16'h0020);
    repeat (2) send_item(ACT_POP, '0, '0);
  endtask

  // sorted fill to the limit, dropped pushes, then drain past empty
  task automatic test_full_list();
    int unsigned n;
    set_strategy(STRAT_BEST);
    for (n = 0; n < DEPTH + 2; n++) begin
      send_item(n[0] ? ACT_PUSH_DEP : ACT_PUSH, ID_W'($urandom), RATE_W'($urandom_range(0, 31)));
    end
    send_item(ACT_FIND, ID_W'($urandom), '0);
    repeat (DEPTH + 1) send_item(ACT_POP, '0, '0);
  endtask

  task automatic test_random(input int unsigned n_items, input int unsigned idle_pct);
    int unsigned              chunk;
    int unsigned              roll;
    int unsigned              push_share;
    logic [ActionWidth-1:0]   act;
    logic [ID_W-1:0]          id;
    logic [RATE_W-1:0]        rate;
    sender_idle_pct = idle_pct;
    for (chunk = 0; chunk < n_items / ChunkLen; chunk++) begin
      set_strategy(StrategyWidth'(chunk));
      // growing, balanced or draining bursts
      push_share = (chunk % 3 == 0) ? 65 : (chunk % 3 == 1) ? 45 : 25;
      repeat (ChunkLen) begin
        roll = $urandom_range(0, 99);
        if (roll < push_share) act = $urandom_range(0, 1) ? ACT_PUSH_DEP : ACT_PUSH;
        else if (roll < push_share + 12) act = ACT_FIND;
        else if (roll < push_share + 20) act = ACT_REMOVE;
        else if (roll < push_share + 23) act = ActionWidth'($urandom_range(ACT_UNUSED_LO,
                                                                         ACT_UNUSED_HI));
        else act = ACT_POP;
        // small pools give find and remove hits and equal ratings
        id   = ($urandom_range(0, 3) == 0) ? ID_W'($urandom) : ID_W'($urandom_range(0, 15));
        rate = ($urandom_range(0, 2) == 0) ? RATE_W'($urandom) : RATE_W'($urandom_range(0, 7));
        send_item(act, id, rate);
      end
    end
  endtask

  initial begin
    rst_ni          = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_strategy_i  = STRAT_DFS;
    start           = 1'b0;
    action_i        = ACT_PUSH;
    edge_id_i       = '0;
    rating_i        = '0;
    sender_idle_pct = 36;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_basic();
    test_best_first();
    test_unused_strategy();
    test_full_list();
    test_random(600, 36);
    test_random(600, 68);
    test_random(600, 0);

    wait_idle();
    repeat (10) @(negedge clk_i);
    if (mismatches == 0 && due_wr == due_rd) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/swl_pkg.sv
hw/rtl/swl_ram.sv
hw/rtl/strategy_work_list.sv
hw/rtl/swl_checker.sv
tb/tb_top.sv
